### hdl/kexp_pkg.sv
// ----------------------------------------------------------------------------
// Key expansion package
// Shared types, the S-box table and the round constant lookup for the
// extended 256-bit key schedule.
// ----------------------------------------------------------------------------
package kexp_pkg;

	localparam int IDX_W = 5;
	localparam int MAX_ROUND_KEYS = 30;
	localparam int MIN_ROUND_KEYS = 2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [63:0] w3;
		logic [63:0] w2;
		logic [63:0] w1;
		logic [63:0] w0;
	} cipher_key_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] sel);
		logic [7:0] r;
		case (sel)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			4'd10: r = 8'h6c;
			4'd11: r = 8'hd8;
			4'd12: r = 8'hab;
			4'd13: r = 8'h4d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

### hdl/kexp_front.sv
// ----------------------------------------------------------------------------
// Key expansion front end
// Accepts cipher key requests into a two-entry queue that feeds the
// round key generator.
// ----------------------------------------------------------------------------
module kexp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_valid,
	output logic                  key_stall,
	input  kexp_pkg::cipher_key_t key_in,
	output kexp_pkg::cipher_key_t key_out,
	output logic                  head_valid,
	input  logic                  head_pop
);

	kexp_pkg::cipher_key_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign key_stall  = (cnt_q == 2'd2);
	assign push       = key_valid & ~key_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign key_out    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, head_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/kexp_back.sv
// ----------------------------------------------------------------------------
// Key expansion back end
// One 128-bit round key per cycle unless stalled: two from the cipher key,
// then each from the prior two, held in an output register until taken.
// ----------------------------------------------------------------------------
module kexp_back #(
	parameter int NUM_ROUND_KEYS = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kexp_pkg::cipher_key_t key_in,
	input  logic                  head_valid,
	output logic                  head_pop,
	output logic                  round_valid,
	input  logic                  round_stall,
	output kexp_pkg::idx_t        round_index,
	output logic [63:0]           round_key_low,
	output logic [63:0]           round_key_high,
	output logic                  last_key
);

	localparam int TOTAL = (NUM_ROUND_KEYS < kexp_pkg::MIN_ROUND_KEYS) ?
		kexp_pkg::MIN_ROUND_KEYS : ((NUM_ROUND_KEYS > kexp_pkg::MAX_ROUND_KEYS) ?
		kexp_pkg::MAX_ROUND_KEYS : NUM_ROUND_KEYS);
	localparam kexp_pkg::idx_t LAST_IDX = kexp_pkg::idx_t'(TOTAL - 1);

	logic           busy_q;
	kexp_pkg::idx_t idx_q;
	logic [127:0]   ka_q;
	logic [127:0]   kb_q;
	logic           adv;
	logic [31:0]    t_sub;
	logic [31:0]    t_mix;
	logic [31:0]    w0, w1, w2, w3;
	logic [127:0]   next_key;

	assign adv      = ~round_valid | ~round_stall;
	assign head_pop = adv & ~busy_q & head_valid;

	assign t_sub = kexp_pkg::sub_word(kb_q[127:96]);
	assign t_mix = idx_q[0] ? t_sub :
		({t_sub[7:0], t_sub[31:8]} ^ {24'h0, kexp_pkg::rcon(idx_q[4:1] - 4'd1)});
	assign w0 = ka_q[31:0] ^ t_mix;
	assign w1 = ka_q[63:32] ^ w0;
	assign w2 = ka_q[95:64] ^ w1;
	assign w3 = ka_q[127:96] ^ w2;
	assign next_key = (idx_q == kexp_pkg::idx_t'(1)) ? kb_q : {w3, w2, w1, w0};

	always_ff @(posedge clk) begin
		if (head_pop) begin
			ka_q           <= {key_in.w1, key_in.w0};
			kb_q           <= {key_in.w3, key_in.w2};
			round_key_low  <= key_in.w0;
			round_key_high <= key_in.w1;
		end else if (adv && busy_q) begin
			if (idx_q != kexp_pkg::idx_t'(1)) begin
				ka_q <= kb_q;
				kb_q <= next_key;
			end
			round_key_low  <= next_key[63:0];
			round_key_high <= next_key[127:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			round_valid <= 1'b0;
			round_index <= '0;
			last_key    <= 1'b0;
		end else if (adv) begin
			round_valid <= busy_q | head_valid;
			if (busy_q) begin
				round_index <= idx_q;
				last_key    <= (idx_q == LAST_IDX);
				busy_q      <= (idx_q != LAST_IDX);
				idx_q       <= idx_q + kexp_pkg::idx_t'(1);
			end else if (head_valid) begin
				round_index <= '0;
				last_key    <= 1'b0;
				busy_q      <= 1'b1;
				idx_q       <= kexp_pkg::idx_t'(1);
			end
		end
	end

endmodule

### hdl/rijndael_256bit_key_expansion.sv
// ----------------------------------------------------------------------------
// Extended 256-bit key expansion
// Turns each cipher key request into a run of 128-bit round keys.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  key      in         key_valid / key_stall   key_bytes_0_7 .. key_bytes_24_31
//  round    out        round_valid / round_stall
//                                              round_index, round_key_low,
//                                              round_key_high, last_key
//
// Each request yields NUM_ROUND_KEYS results, clamped to 2 .. 30, one per
// cycle from the round key generator while round_stall is low, and
// runs follow each other with no gap. A two-entry queue takes new requests
// while the generator works. The output register holds a result while
// round_stall is high and the generator waits behind it. Reset clears
// the queue and the generator; no clearing pass is needed.
module rijndael_256bit_key_expansion #(
	parameter int NUM_ROUND_KEYS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_stall,
	input  logic [63:0] key_bytes_0_7,
	input  logic [63:0] key_bytes_8_15,
	input  logic [63:0] key_bytes_16_23,
	input  logic [63:0] key_bytes_24_31,
	output logic        round_valid,
	input  logic        round_stall,
	output logic [4:0]  round_index,
	output logic [63:0] round_key_low,
	output logic [63:0] round_key_high,
	output logic        last_key
);

	kexp_pkg::cipher_key_t key_in;
	kexp_pkg::cipher_key_t key_head;
	logic                  head_valid;
	logic                  head_pop;

	assign key_in = '{w3: key_bytes_24_31, w2: key_bytes_16_23,
		w1: key_bytes_8_15, w0: key_bytes_0_7};

	kexp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_in     (key_in),
		.key_out    (key_head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	kexp_back #(
		.NUM_ROUND_KEYS (NUM_ROUND_KEYS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.key_in         (key_head),
		.head_valid     (head_valid),
		.head_pop       (head_pop),
		.round_valid    (round_valid),
		.round_stall    (round_stall),
		.round_index    (round_index),
		.round_key_low  (round_key_low),
		.round_key_high (round_key_high),
		.last_key       (last_key)
	);

endmodule

### hdl/kexp_checker.sv
// ----------------------------------------------------------------------------
// Key expansion checker
// Port-level assertions on the round key output sequence.
// ----------------------------------------------------------------------------
module kexp_checker #(
	parameter int NUM_ROUND_KEYS = 30
) (
	input logic        clk,
	input logic        arst_n,
	input logic        round_valid,
	input logic        round_stall,
	input logic [4:0]  round_index,
	input logic [63:0] round_key_low,
	input logic        last_key
);

	localparam int TOTAL = (NUM_ROUND_KEYS < 2) ? 2 :
		((NUM_ROUND_KEYS > 30) ? 30 : NUM_ROUND_KEYS);
	localparam logic [4:0] LAST_IDX = 5'(TOTAL - 1);

	// A run continues without a gap until its final key.
	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && !round_stall && !last_key) |=>
		(round_valid && round_index == $past(round_index) + 5'd1))
		else $error("round key run broke before its final key");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && last_key) |-> (round_index == LAST_IDX))
		else $error("final round key flagged at wrong index");

	a_new_run: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && !round_stall && last_key) |=>
		(!round_valid || round_index == 5'd0))
		else $error("new run does not start at index zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && round_stall) |=>
		(round_valid && $stable(round_index) && $stable(round_key_low)))
		else $error("stalled round key request changed");

endmodule

bind rijndael_256bit_key_expansion kexp_checker #(
	.NUM_ROUND_KEYS (NUM_ROUND_KEYS)
) u_kexp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.round_valid   (round_valid),
	.round_stall   (round_stall),
	.round_index   (round_index),
	.round_key_low (round_key_low),
	.last_key      (last_key)
);
